@@ rtl/vbc_pkg.sv @@
// ----------------------------------------------------------------------------
// vbc_pkg
// Shared types, widths and register codes for the velocity budget clamp.
// ----------------------------------------------------------------------------
package vbc_pkg;

  localparam int VEL_W     = 24;
  localparam int LIM_W     = 23;
  localparam int GAIN_W    = 17;
  localparam int IDX_W     = 3;

  // divider cells: 40-bit dividend/quotient, 41-bit divisor
  localparam int DIV_W     = 40;
  localparam int DEN_W     = 41;
  localparam int REM_W     = 42;

  // square-root cells: 54-bit radicand, 27-bit root
  localparam int SQ_RAD_W  = 54;
  localparam int SQ_ROOT_W = 27;
  localparam int SQ_REM_W  = 30;

  localparam int Q_W       = 26;   // q_i after normalising shift
  localparam int SHIFT_W   = 4;
  localparam int BUD_W     = 17;

  localparam int LAT = 1 + DIV_W + 4 + SQ_ROOT_W + 1 + DIV_W + 1;

  localparam logic [LIM_W-1:0]  LIM_RST  = 23'd655360;
  localparam logic [GAIN_W-1:0] GAIN_ONE = 17'd65536;

  typedef enum logic [IDX_W-1:0] {
    REG_MAX_X,
    REG_MAX_Y,
    REG_MAX_Z,
    REG_MAX_YAW,
    REG_GAIN
  } cfg_reg_t;

  typedef struct packed {
    logic signed [VEL_W-1:0] vel_x;
    logic signed [VEL_W-1:0] vel_y;
    logic signed [VEL_W-1:0] vel_z;
    logic signed [VEL_W-1:0] yaw_rate;
  } in_t;

  typedef struct packed {
    logic signed [VEL_W-1:0] lim_x;
    logic signed [VEL_W-1:0] lim_y;
    logic signed [VEL_W-1:0] lim_z;
    logic signed [VEL_W-1:0] lim_yaw_rate;
    logic                    was_scaled;
  } out_t;

  typedef struct packed {
    logic [DEN_W-1:0] rem;
    logic [DIV_W-1:0] num;
    logic [DIV_W-1:0] quo;
    logic [DEN_W-1:0] den;
  } div_t;

  typedef struct packed {
    logic [SQ_REM_W-1:0]  rem;
    logic [SQ_RAD_W-1:0]  rad;
    logic [SQ_ROOT_W-1:0] root;
  } sqrt_t;

  function automatic logic [VEL_W-1:0] mag(input logic [VEL_W-1:0] v);
    logic [VEL_W-1:0] r;
    r = v[VEL_W-1] ? (~v + 1'b1) : v;
    return r;
  endfunction

endpackage

@@ rtl/velocity_budget_clamp.sv @@
// ----------------------------------------------------------------------------
// velocity_budget_clamp
// Clamps yaw rate, then scales x/y/z into the elliptical budget left over.
// ----------------------------------------------------------------------------
//  channel | ports                          | timing
//  in      | start, busy, in_data           | one word per cycle, busy always 0
//  out     | out_valid, out_data            | one-cycle strobe per word
//  cfg     | cfg_we, cfg_index, cfg_wdata   | written at the edge, no wait
//
// A word passes from start to out_valid through the chains of cells: 40
// divider cells for the axis and yaw ratios, 27 root cells for the magnitude
// and budget, 40 divider cells for the final scaling. A new word enters every
// cycle. Reset clears the valid line and loads the register defaults; the
// receiver cannot stall, so nothing ever holds.
// ----------------------------------------------------------------------------
module velocity_budget_clamp (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  vbc_pkg::in_t               in_data,
  output logic                       out_valid,
  output vbc_pkg::out_t              out_data,
  input  logic                       cfg_we,
  input  logic [vbc_pkg::IDX_W-1:0]  cfg_index,
  input  logic [vbc_pkg::LIM_W-1:0]  cfg_wdata
);

  typedef struct packed {
    logic [2:0][vbc_pkg::VEL_W-1:0] v;
    logic [vbc_pkg::VEL_W-1:0]      yaw;
    logic [vbc_pkg::GAIN_W-1:0]     k;
  } sba_t;

  typedef struct packed {
    logic [2:0][vbc_pkg::VEL_W-1:0] v;
    logic [vbc_pkg::VEL_W-1:0]      yaw;
    logic [vbc_pkg::SHIFT_W-1:0]    s;
  } sbb_t;

  typedef struct packed {
    logic [2:0][vbc_pkg::VEL_W-1:0] v;
    logic [vbc_pkg::VEL_W-1:0]      yaw;
    logic                           scaled;
  } sbc_t;

  // configuration
  logic [vbc_pkg::LIM_W-1:0]  max_x_r, max_y_r, max_z_r, max_yaw_r;
  logic [vbc_pkg::GAIN_W-1:0] gain_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_x_r   <= vbc_pkg::LIM_RST;
      max_y_r   <= vbc_pkg::LIM_RST;
      max_z_r   <= vbc_pkg::LIM_RST;
      max_yaw_r <= vbc_pkg::LIM_RST;
      gain_r    <= vbc_pkg::GAIN_ONE;
    end else if (cfg_we) begin
      case (vbc_pkg::cfg_reg_t'(cfg_index))
        vbc_pkg::REG_MAX_X:   max_x_r   <= cfg_wdata;
        vbc_pkg::REG_MAX_Y:   max_y_r   <= cfg_wdata;
        vbc_pkg::REG_MAX_Z:   max_z_r   <= cfg_wdata;
        vbc_pkg::REG_MAX_YAW: max_yaw_r <= cfg_wdata;
        vbc_pkg::REG_GAIN:    gain_r    <= cfg_wdata[vbc_pkg::GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  // valid line
  logic [vbc_pkg::LAT-1:0] vld_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[vbc_pkg::LAT-2:0], start};
    end
  end

  // ---------------- entry: clamp yaw, zero limits act as one
  logic [vbc_pkg::LIM_W-1:0]   ymax;
  logic signed [24:0]          yaw25, ymax25, yc25;
  logic [2:0][vbc_pkg::LIM_W-1:0] lims;
  logic [2:0][vbc_pkg::VEL_W-1:0] vin;
  logic [vbc_pkg::VEL_W-1:0]   yc, ayaw;
  logic [vbc_pkg::GAIN_W-1:0]  kc;

  always_comb begin
    ymax   = (max_yaw_r == '0) ? {{(vbc_pkg::LIM_W-1){1'b0}}, 1'b1} : max_yaw_r;
    lims[0] = (max_x_r == '0) ? {{(vbc_pkg::LIM_W-1){1'b0}}, 1'b1} : max_x_r;
    lims[1] = (max_y_r == '0) ? {{(vbc_pkg::LIM_W-1){1'b0}}, 1'b1} : max_y_r;
    lims[2] = (max_z_r == '0) ? {{(vbc_pkg::LIM_W-1){1'b0}}, 1'b1} : max_z_r;
    vin[0] = in_data.vel_x;
    vin[1] = in_data.vel_y;
    vin[2] = in_data.vel_z;
    yaw25  = {in_data.yaw_rate[vbc_pkg::VEL_W-1], in_data.yaw_rate};
    ymax25 = {2'b00, ymax};
    if (yaw25 > ymax25) begin
      yc25 = ymax25;
    end else if (yaw25 < -ymax25) begin
      yc25 = -ymax25;
    end else begin
      yc25 = yaw25;
    end
    yc   = yc25[vbc_pkg::VEL_W-1:0];
    ayaw = vbc_pkg::mag(yc);
    kc   = (gain_r > vbc_pkg::GAIN_ONE) ? vbc_pkg::GAIN_ONE : gain_r;
  end

  vbc_pkg::div_t diva0_r [4];
  sba_t          sba_r   [0:vbc_pkg::DIV_W];

  always_ff @(posedge clk) begin
    for (int j = 0; j < 3; j++) begin
      diva0_r[j].rem <= '0;
      diva0_r[j].quo <= '0;
      diva0_r[j].num <= {vbc_pkg::mag(vin[j]), 16'd0};
      diva0_r[j].den <= {18'd0, lims[j]};
    end
    diva0_r[3].rem <= '0;
    diva0_r[3].quo <= '0;
    diva0_r[3].num <= {ayaw, 16'd0};
    diva0_r[3].den <= {18'd0, ymax};
    sba_r[0].v     <= vin;
    sba_r[0].yaw   <= yc;
    sba_r[0].k     <= kc;
    for (int i = 1; i <= vbc_pkg::DIV_W; i++) begin
      sba_r[i] <= sba_r[i-1];
    end
  end

  // ---------------- first divider row: q_i and yaw ratio
  vbc_pkg::div_t diva [4][0:vbc_pkg::DIV_W];

  for (genvar j = 0; j < 4; j++) begin : g_diva
    assign diva[j][0] = diva0_r[j];
    for (genvar i = 0; i < vbc_pkg::DIV_W; i++) begin : g_cell
      vbc_div_cell u_cell (.clk(clk), .d_in(diva[j][i]), .d_out(diva[j][i+1]));
    end
  end

  // ---------------- arithmetic between the rows
  logic [33:0]                    rsq_r;
  logic [2:0][vbc_pkg::DIV_W-1:0] q_r;
  logic [vbc_pkg::DIV_W-1:0]      qmax_nxt, qmax_r;
  sba_t                           sb1_r, sb2_r, sb3_r;
  logic [vbc_pkg::GAIN_W-1:0]     ratio;

  always_comb begin
    ratio    = diva[3][vbc_pkg::DIV_W].quo[vbc_pkg::GAIN_W-1:0];
    qmax_nxt = diva[0][vbc_pkg::DIV_W].quo;
    for (int j = 1; j < 3; j++) begin
      if (diva[j][vbc_pkg::DIV_W].quo > qmax_nxt) begin
        qmax_nxt = diva[j][vbc_pkg::DIV_W].quo;
      end
    end
  end

  always_ff @(posedge clk) begin
    rsq_r  <= ratio * ratio;
    for (int j = 0; j < 3; j++) begin
      q_r[j] <= diva[j][vbc_pkg::DIV_W].quo;
    end
    qmax_r <= qmax_nxt;
    sb1_r  <= sba_r[vbc_pkg::DIV_W];
  end

  // normalising shift: smallest s with every q_i >> s below 2^26
  logic [vbc_pkg::SHIFT_W-1:0]   s_nxt, s2_r, s3_r;
  logic [50:0]                   kprod;
  logic [32:0]                   ksq_r;
  logic [2:0][vbc_pkg::Q_W-1:0]  t_r;
  logic [vbc_pkg::DIV_W-1:0]     tsh [3];

  always_comb begin
    s_nxt = '0;
    for (int b = vbc_pkg::Q_W; b < vbc_pkg::DIV_W; b++) begin
      if (qmax_r[b]) begin
        s_nxt = vbc_pkg::SHIFT_W'(b - vbc_pkg::Q_W + 1);
      end
    end
    kprod = sb1_r.k * rsq_r;
    for (int j = 0; j < 3; j++) begin
      tsh[j] = q_r[j] >> s_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ksq_r <= (kprod[50:16] > 35'h100000000) ? 33'h100000000 : kprod[48:16];
    s2_r  <= s_nxt;
    for (int j = 0; j < 3; j++) begin
      t_r[j] <= tsh[j][vbc_pkg::Q_W-1:0];
    end
    sb2_r <= sb1_r;
  end

  logic [32:0]       radb_r;
  logic [2:0][51:0]  tsq_r;

  always_ff @(posedge clk) begin
    radb_r <= 33'h100000000 - ksq_r;
    for (int j = 0; j < 3; j++) begin
      tsq_r[j] <= t_r[j] * t_r[j];
    end
    s3_r  <= s2_r;
    sb3_r <= sb2_r;
  end

  // ---------------- root row: magnitude and budget
  vbc_pkg::sqrt_t sq0_r [2];
  sbb_t           sbb_r [0:vbc_pkg::SQ_ROOT_W];

  always_ff @(posedge clk) begin
    sq0_r[0].rem  <= '0;
    sq0_r[0].root <= '0;
    sq0_r[0].rad  <= {2'b00, tsq_r[0]} + {2'b00, tsq_r[1]} + {2'b00, tsq_r[2]};
    sq0_r[1].rem  <= '0;
    sq0_r[1].root <= '0;
    sq0_r[1].rad  <= {21'd0, radb_r};
    sbb_r[0].v    <= sb3_r.v;
    sbb_r[0].yaw  <= sb3_r.yaw;
    sbb_r[0].s    <= s3_r;
    for (int i = 1; i <= vbc_pkg::SQ_ROOT_W; i++) begin
      sbb_r[i] <= sbb_r[i-1];
    end
  end

  vbc_pkg::sqrt_t sq [2][0:vbc_pkg::SQ_ROOT_W];

  for (genvar j = 0; j < 2; j++) begin : g_sq
    assign sq[j][0] = sq0_r[j];
    for (genvar i = 0; i < vbc_pkg::SQ_ROOT_W; i++) begin : g_cell
      vbc_sqrt_cell u_cell (.clk(clk), .d_in(sq[j][i]), .d_out(sq[j][i+1]));
    end
  end

  // ---------------- scale decision and final divider row
  logic [vbc_pkg::DEN_W-1:0] mag_m;
  logic [vbc_pkg::BUD_W-1:0] budget;
  logic                      scaled;
  logic [40:0]               vprod [3];
  sbb_t                      sbe;

  always_comb begin
    sbe    = sbb_r[vbc_pkg::SQ_ROOT_W];
    mag_m  = {14'd0, sq[0][vbc_pkg::SQ_ROOT_W].root} << sbe.s;
    budget = sq[1][vbc_pkg::SQ_ROOT_W].root[vbc_pkg::BUD_W-1:0];
    scaled = mag_m > {24'd0, budget};
    for (int j = 0; j < 3; j++) begin
      vprod[j] = vbc_pkg::mag(sbe.v[j]) * budget;
    end
  end

  vbc_pkg::div_t divb0_r [3];
  sbc_t          sbc_r   [0:vbc_pkg::DIV_W];

  always_ff @(posedge clk) begin
    for (int j = 0; j < 3; j++) begin
      divb0_r[j].rem <= '0;
      divb0_r[j].quo <= '0;
      divb0_r[j].num <= vprod[j][vbc_pkg::DIV_W-1:0];
      divb0_r[j].den <= mag_m;
    end
    sbc_r[0].v      <= sbe.v;
    sbc_r[0].yaw    <= sbe.yaw;
    sbc_r[0].scaled <= scaled;
    for (int i = 1; i <= vbc_pkg::DIV_W; i++) begin
      sbc_r[i] <= sbc_r[i-1];
    end
  end

  vbc_pkg::div_t divb [3][0:vbc_pkg::DIV_W];

  for (genvar j = 0; j < 3; j++) begin : g_divb
    assign divb[j][0] = divb0_r[j];
    for (genvar i = 0; i < vbc_pkg::DIV_W; i++) begin : g_cell
      vbc_div_cell u_cell (.clk(clk), .d_in(divb[j][i]), .d_out(divb[j][i+1]));
    end
  end

  // ---------------- output word
  logic [2:0][vbc_pkg::VEL_W-1:0] res;
  logic [vbc_pkg::VEL_W-1:0]      aq;
  sbc_t                           sbo;
  vbc_pkg::out_t                  out_r;

  always_comb begin
    sbo = sbc_r[vbc_pkg::DIV_W];
    for (int j = 0; j < 3; j++) begin
      aq = divb[j][vbc_pkg::DIV_W].quo[vbc_pkg::VEL_W-1:0];
      if (sbo.scaled) begin
        res[j] = sbo.v[j][vbc_pkg::VEL_W-1] ? (~aq + 1'b1) : aq;
      end else begin
        res[j] = sbo.v[j];
      end
    end
  end

  always_ff @(posedge clk) begin
    out_r.lim_x        <= res[0];
    out_r.lim_y        <= res[1];
    out_r.lim_z        <= res[2];
    out_r.lim_yaw_rate <= sbo.yaw;
    out_r.was_scaled   <= sbo.scaled;
  end

  assign out_data  = out_r;
  assign out_valid = vld_r[vbc_pkg::LAT-1];

endmodule

@@ rtl/vbc_div_cell.sv @@
// ----------------------------------------------------------------------------
// vbc_div_cell
// One restoring division step: one quotient bit per cell, registered.
// ----------------------------------------------------------------------------
module vbc_div_cell (
  input  logic          clk,
  input  vbc_pkg::div_t d_in,
  output vbc_pkg::div_t d_out
);

  vbc_pkg::div_t                 d_r;
  vbc_pkg::div_t                 d_nxt;
  logic [vbc_pkg::REM_W-1:0]     rs;
  logic [vbc_pkg::REM_W-1:0]     dif;

  always_comb begin
    rs        = {d_in.rem, d_in.num[vbc_pkg::DIV_W-1]};
    dif       = rs - {1'b0, d_in.den};
    d_nxt.den = d_in.den;
    d_nxt.num = {d_in.num[vbc_pkg::DIV_W-2:0], 1'b0};
    if (rs >= {1'b0, d_in.den}) begin
      d_nxt.rem = dif[vbc_pkg::DEN_W-1:0];
      d_nxt.quo = {d_in.quo[vbc_pkg::DIV_W-2:0], 1'b1};
    end else begin
      d_nxt.rem = rs[vbc_pkg::DEN_W-1:0];
      d_nxt.quo = {d_in.quo[vbc_pkg::DIV_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    d_r <= d_nxt;
  end

  assign d_out = d_r;

endmodule

@@ rtl/vbc_sqrt_cell.sv @@
// ----------------------------------------------------------------------------
// vbc_sqrt_cell
// One digit-pair step of an integer square root, one root bit per cell.
// ----------------------------------------------------------------------------
module vbc_sqrt_cell (
  input  logic           clk,
  input  vbc_pkg::sqrt_t d_in,
  output vbc_pkg::sqrt_t d_out
);

  vbc_pkg::sqrt_t                d_r;
  vbc_pkg::sqrt_t                d_nxt;
  logic [vbc_pkg::SQ_REM_W-1:0]  rs;
  logic [vbc_pkg::SQ_REM_W-1:0]  trial;

  always_comb begin
    rs    = {d_in.rem[vbc_pkg::SQ_REM_W-3:0], d_in.rad[vbc_pkg::SQ_RAD_W-1 -: 2]};
    trial = {1'b0, d_in.root, 2'b01};
    d_nxt.rad = {d_in.rad[vbc_pkg::SQ_RAD_W-3:0], 2'b00};
    if (rs >= trial) begin
      d_nxt.rem  = rs - trial;
      d_nxt.root = {d_in.root[vbc_pkg::SQ_ROOT_W-2:0], 1'b1};
    end else begin
      d_nxt.rem  = rs;
      d_nxt.root = {d_in.root[vbc_pkg::SQ_ROOT_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    d_r <= d_nxt;
  end

  assign d_out = d_r;

endmodule
